@@ src/rbp_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and elaboration-time tables for the ramp Blinn-Phong shader.
// Used by every file of the block; depends on nothing.
package rbp_pkg;

    // configuration port
    localparam int CFG_W = 16;
    localparam int IDX_W = 3;
    localparam logic [IDX_W-1:0] REG_AMB_RED   = 3'd0;
    localparam logic [IDX_W-1:0] REG_AMB_GREEN = 3'd1;
    localparam logic [IDX_W-1:0] REG_AMB_BLUE  = 3'd2;
    localparam logic [IDX_W-1:0] REG_SPEC_RED  = 3'd3;
    localparam logic [IDX_W-1:0] REG_SPEC_GRN  = 3'd4;
    localparam logic [IDX_W-1:0] REG_SPEC_BLUE = 3'd5;
    localparam logic [IDX_W-1:0] REG_SHININESS = 3'd6;
    localparam logic [CFG_W-1:0] SHIN_RESET    = 16'd256;

    // datapath widths
    localparam int HH_W      = 34;          // |h|^2
    localparam int DH_W      = 35;          // h.n, signed
    localparam int DN_W      = 34;          // wIn.n, signed
    localparam int SQ_W      = 17;          // floor(sqrt(|h|^2))
    localparam int SQ_STEPS  = HH_W / 2;
    localparam int REM_W     = SQ_W + 1;
    localparam int NUM_W     = 34;
    localparam int C_W       = 15;          // cosine, Q.14, 0..1.0
    localparam int DIV_STEPS = C_W;
    localparam logic [C_W-1:0] ONE_Q14 = 15'd16384;
    localparam int M_W       = 16;          // log2 mantissa, Q1.15
    localparam int LOG_STEPS = 16;
    localparam int NEG_W     = 20;          // -log2(c), Q4.16
    localparam int IP_W      = 12;
    localparam int F_W       = 16;
    localparam int EXP_STEPS = F_W;
    localparam int R_W       = 31;          // exp2 product, Q.30
    localparam int W_W       = 17;          // power, Q.16, up to 1.0
    localparam int RAMP_W    = 13;
    localparam int DIFF_W    = 18;

    // accept edge to strobe, in cycles
    localparam int LATENCY = 4 + SQ_STEPS + 1 + DIV_STEPS + 1
                           + 1 + LOG_STEPS + 1 + EXP_STEPS + 1 + 2;

    typedef logic signed [DIFF_W-1:0] diff_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] red;
        logic signed [DIFF_W-1:0] green;
        logic signed [DIFF_W-1:0] blue;
    } tag_t;

    // ramp points: gray, dark gray, red, orange, yellow
    localparam logic [RAMP_W-1:0] RAMP_PTS [5][3] = '{
        '{13'd1638, 13'd1638, 13'd1638},
        '{13'd819,  13'd819,  13'd819 },
        '{13'd4096, 13'd0,    13'd0   },
        '{13'd4096, 13'd2458, 13'd0   },
        '{13'd6963, 13'd5325, 13'd4096}
    };

    typedef logic [R_W-1:0] fac_tab_t [0:EXP_STEPS];

    function automatic logic [63:0] isqrt_c(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = v;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(-2^-k) in Q.30, by repeated square roots starting from 0.5
    function automatic fac_tab_t make_exp_fac();
        fac_tab_t t;
        logic [63:0] v;
        t[0] = 31'h2000_0000;
        for (int k = 1; k <= EXP_STEPS; k++)
        begin
            v = 64'(t[k-1]) << 30;
            t[k] = R_W'(isqrt_c(v));
        end
        return t;
    endfunction

    localparam fac_tab_t EXP_FAC = make_exp_fac();

endpackage

@@ src/rbp_rootdiv.sv @@
`timescale 1ns / 1ps
// Cosine unit: pipelined square root of |h|^2, then h.n / |h| clamped to [0, 1.0].
// Depends on rbp_pkg.
module rbp_rootdiv (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_vld,
    input  logic [rbp_pkg::HH_W-1:0]   in_hh,
    input  logic signed [rbp_pkg::DH_W-1:0] in_dh,
    input  rbp_pkg::tag_t              in_tag,
    output logic                       out_vld,
    output logic [rbp_pkg::C_W-1:0]    out_c,
    output rbp_pkg::tag_t              out_tag
);
    import rbp_pkg::*;

    logic                   sq_vld_reg  [SQ_STEPS];
    logic [HH_W-1:0]        sq_v_reg    [SQ_STEPS];
    logic [REM_W-1:0]       sq_rem_reg  [SQ_STEPS];
    logic [SQ_W-1:0]        sq_root_reg [SQ_STEPS];
    logic signed [DH_W-1:0] sq_dh_reg   [SQ_STEPS];
    tag_t                   sq_tag_reg  [SQ_STEPS];

    // one root bit per stage, two radicand bits shifted in
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sq
        logic                   p_vld;
        logic [HH_W-1:0]        p_v;
        logic [REM_W-1:0]       p_rem;
        logic [SQ_W-1:0]        p_root;
        logic signed [DH_W-1:0] p_dh;
        tag_t                   p_tag;
        logic [REM_W+1:0]       rem_sh;
        logic [REM_W+1:0]       trial;
        logic [REM_W-1:0]       rem_next;
        logic [SQ_W-1:0]        root_next;

        if (k == 0)
        begin : g_first
            assign p_vld  = in_vld;
            assign p_v    = in_hh;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_dh   = in_dh;
            assign p_tag  = in_tag;
        end
        else
        begin : g_rest
            assign p_vld  = sq_vld_reg[k-1];
            assign p_v    = sq_v_reg[k-1];
            assign p_rem  = sq_rem_reg[k-1];
            assign p_root = sq_root_reg[k-1];
            assign p_dh   = sq_dh_reg[k-1];
            assign p_tag  = sq_tag_reg[k-1];
        end

        always_comb
        begin
            rem_sh = {p_rem, p_v[HH_W-1 -: 2]};
            trial  = {1'b0, p_root, 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = REM_W'(rem_sh - trial);
                root_next = {p_root[SQ_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[REM_W-1:0];
                root_next = {p_root[SQ_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[k] <= 1'b0;
            end
            else
            begin
                sq_vld_reg[k] <= p_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            sq_v_reg[k]    <= {p_v[HH_W-3:0], 2'b00};
            sq_rem_reg[k]  <= rem_next;
            sq_root_reg[k] <= root_next;
            sq_dh_reg[k]   <= p_dh;
            sq_tag_reg[k]  <= p_tag;
        end
    end

    // divide setup: sign test and overflow test
    logic             dv0_vld_reg;
    logic             dv0_pos_reg;
    logic             dv0_ovf_reg;
    logic [NUM_W-1:0] dv0_num_reg;
    logic [SQ_W-1:0]  dv0_den_reg;
    tag_t             dv0_tag_reg;
    logic [SQ_W-1:0]        s_last;
    logic signed [DH_W-1:0] dh_last;

    assign s_last  = sq_root_reg[SQ_STEPS-1];
    assign dh_last = sq_dh_reg[SQ_STEPS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv0_vld_reg <= 1'b0;
        end
        else
        begin
            dv0_vld_reg <= sq_vld_reg[SQ_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        dv0_pos_reg <= !dh_last[DH_W-1] && (dh_last != '0) && (s_last != '0);
        dv0_ovf_reg <= dh_last[NUM_W-1:0] >= NUM_W'({s_last, {C_W{1'b0}}});
        dv0_num_reg <= dh_last[NUM_W-1:0];
        dv0_den_reg <= s_last;
        dv0_tag_reg <= sq_tag_reg[SQ_STEPS-1];
    end

    logic             dv_vld_reg [DIV_STEPS];
    logic             dv_pos_reg [DIV_STEPS];
    logic             dv_ovf_reg [DIV_STEPS];
    logic [NUM_W-1:0] dv_num_reg [DIV_STEPS];
    logic [SQ_W-1:0]  dv_den_reg [DIV_STEPS];
    logic [C_W-1:0]   dv_q_reg   [DIV_STEPS];
    tag_t             dv_tag_reg [DIV_STEPS];

    // restoring division, quotient bit C_W-1-k at stage k
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        localparam int QB = C_W - 1 - k;
        logic             p_vld;
        logic             p_pos;
        logic             p_ovf;
        logic [NUM_W-1:0] p_num;
        logic [SQ_W-1:0]  p_den;
        logic [C_W-1:0]   p_q;
        tag_t             p_tag;
        logic [NUM_W-1:0] shifted;
        logic [NUM_W-1:0] num_next;
        logic [C_W-1:0]   q_next;

        if (k == 0)
        begin : g_first
            assign p_vld = dv0_vld_reg;
            assign p_pos = dv0_pos_reg;
            assign p_ovf = dv0_ovf_reg;
            assign p_num = dv0_num_reg;
            assign p_den = dv0_den_reg;
            assign p_q   = '0;
            assign p_tag = dv0_tag_reg;
        end
        else
        begin : g_rest
            assign p_vld = dv_vld_reg[k-1];
            assign p_pos = dv_pos_reg[k-1];
            assign p_ovf = dv_ovf_reg[k-1];
            assign p_num = dv_num_reg[k-1];
            assign p_den = dv_den_reg[k-1];
            assign p_q   = dv_q_reg[k-1];
            assign p_tag = dv_tag_reg[k-1];
        end

        always_comb
        begin
            shifted = NUM_W'(p_den) << QB;
            num_next = p_num;
            q_next   = p_q;
            if (p_num >= shifted)
            begin
                num_next  = p_num - shifted;
                q_next[QB] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[k] <= 1'b0;
            end
            else
            begin
                dv_vld_reg[k] <= p_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            dv_pos_reg[k] <= p_pos;
            dv_ovf_reg[k] <= p_ovf;
            dv_num_reg[k] <= num_next;
            dv_den_reg[k] <= p_den;
            dv_q_reg[k]   <= q_next;
            dv_tag_reg[k] <= p_tag;
        end
    end

    // clamp: nonpositive cosine to zero, above one to one
    logic           c_vld_reg;
    logic [C_W-1:0] c_reg;
    logic [C_W-1:0] c_next;
    tag_t           c_tag_reg;

    always_comb
    begin
        priority if (!dv_pos_reg[DIV_STEPS-1])
        begin
            c_next = '0;
        end
        else if (dv_ovf_reg[DIV_STEPS-1] || (dv_q_reg[DIV_STEPS-1] > ONE_Q14))
        begin
            c_next = ONE_Q14;
        end
        else
        begin
            c_next = dv_q_reg[DIV_STEPS-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
        end
        else
        begin
            c_vld_reg <= dv_vld_reg[DIV_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg     <= c_next;
        c_tag_reg <= dv_tag_reg[DIV_STEPS-1];
    end

    assign out_vld = c_vld_reg;
    assign out_c   = c_reg;
    assign out_tag = c_tag_reg;

endmodule

@@ src/rbp_pow.sv @@
`timescale 1ns / 1ps
// Power unit: c^shininess through a squaring log2 pipeline and an exp2 product pipeline.
// Depends on rbp_pkg (widths, exp2 factor table).
module rbp_pow (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_vld,
    input  logic [rbp_pkg::C_W-1:0]    in_c,
    input  logic [rbp_pkg::CFG_W-1:0]  shin,
    input  rbp_pkg::tag_t              in_tag,
    output logic                       out_vld,
    output logic [rbp_pkg::W_W-1:0]    out_w,
    output rbp_pkg::tag_t              out_tag
);
    import rbp_pkg::*;

    // normalize: exponent and Q1.15 mantissa
    logic           nm_vld_reg;
    logic [3:0]     nm_e_reg;
    logic [M_W-1:0] nm_m_reg;
    logic           nm_zero_reg;
    tag_t           nm_tag_reg;
    logic [3:0]     e_next;

    always_comb
    begin
        e_next = '0;
        for (int i = 0; i < C_W; i++)
        begin
            if (in_c[i])
            begin
                e_next = 4'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nm_vld_reg <= 1'b0;
        end
        else
        begin
            nm_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        nm_e_reg    <= e_next;
        nm_m_reg    <= {1'b0, in_c} << (4'd15 - e_next);
        nm_zero_reg <= (in_c == '0);
        nm_tag_reg  <= in_tag;
    end

    logic           lg_vld_reg  [LOG_STEPS];
    logic [3:0]     lg_e_reg    [LOG_STEPS];
    logic [M_W-1:0] lg_m_reg    [LOG_STEPS];
    logic [F_W-1:0] lg_frac_reg [LOG_STEPS];
    logic           lg_zero_reg [LOG_STEPS];
    tag_t           lg_tag_reg  [LOG_STEPS];

    // one fraction bit of log2 per squaring
    for (genvar k = 0; k < LOG_STEPS; k++)
    begin : g_log
        logic           p_vld;
        logic [3:0]     p_e;
        logic [M_W-1:0] p_m;
        logic [F_W-1:0] p_frac;
        logic           p_zero;
        tag_t           p_tag;
        logic [2*M_W-1:0] sq;
        logic [M_W:0]     ms;
        logic [M_W-1:0]   m_next;

        if (k == 0)
        begin : g_first
            assign p_vld  = nm_vld_reg;
            assign p_e    = nm_e_reg;
            assign p_m    = nm_m_reg;
            assign p_frac = '0;
            assign p_zero = nm_zero_reg;
            assign p_tag  = nm_tag_reg;
        end
        else
        begin : g_rest
            assign p_vld  = lg_vld_reg[k-1];
            assign p_e    = lg_e_reg[k-1];
            assign p_m    = lg_m_reg[k-1];
            assign p_frac = lg_frac_reg[k-1];
            assign p_zero = lg_zero_reg[k-1];
            assign p_tag  = lg_tag_reg[k-1];
        end

        always_comb
        begin
            sq = (2*M_W)'(p_m) * (2*M_W)'(p_m);
            ms = sq[2*M_W-1:M_W-1];
            m_next = ms[M_W] ? ms[M_W:1] : ms[M_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                lg_vld_reg[k] <= 1'b0;
            end
            else
            begin
                lg_vld_reg[k] <= p_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            lg_e_reg[k]    <= p_e;
            lg_m_reg[k]    <= m_next;
            lg_frac_reg[k] <= {p_frac[F_W-2:0], ms[M_W]};
            lg_zero_reg[k] <= p_zero;
            lg_tag_reg[k]  <= p_tag;
        end
    end

    // scale -log2(c) by the exponent
    logic            tm_vld_reg;
    logic [IP_W-1:0] tm_ip_reg;
    logic [F_W-1:0]  tm_f_reg;
    logic            tm_zero_reg;
    logic            tm_pzero_reg;
    tag_t            tm_tag_reg;
    logic [NEG_W-1:0] neg;
    logic [NEG_W+CFG_W-1:0] tprod;

    always_comb
    begin
        neg   = {4'(4'd14 - lg_e_reg[LOG_STEPS-1]), 16'd0}
              - {4'd0, lg_frac_reg[LOG_STEPS-1]};
        tprod = (NEG_W+CFG_W)'(neg) * (NEG_W+CFG_W)'(shin);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tm_vld_reg <= 1'b0;
        end
        else
        begin
            tm_vld_reg <= lg_vld_reg[LOG_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        tm_ip_reg    <= tprod[NEG_W+CFG_W-1 -: IP_W];
        tm_f_reg     <= tprod[8 +: F_W];
        tm_zero_reg  <= lg_zero_reg[LOG_STEPS-1];
        tm_pzero_reg <= (shin == '0);
        tm_tag_reg   <= lg_tag_reg[LOG_STEPS-1];
    end

    logic            ex_vld_reg   [EXP_STEPS];
    logic [IP_W-1:0] ex_ip_reg    [EXP_STEPS];
    logic [F_W-1:0]  ex_f_reg     [EXP_STEPS];
    logic            ex_zero_reg  [EXP_STEPS];
    logic            ex_pzero_reg [EXP_STEPS];
    logic [R_W-1:0]  ex_r_reg     [EXP_STEPS];
    tag_t            ex_tag_reg   [EXP_STEPS];

    // one fraction bit of 2^-t per stage, factor from the table
    for (genvar k = 0; k < EXP_STEPS; k++)
    begin : g_exp
        localparam logic [R_W-1:0] FAC = EXP_FAC[k+1];
        logic            p_vld;
        logic [IP_W-1:0] p_ip;
        logic [F_W-1:0]  p_f;
        logic            p_zero;
        logic            p_pzero;
        logic [R_W-1:0]  p_r;
        tag_t            p_tag;
        logic [2*R_W-1:0] prod;
        logic [R_W-1:0]   r_next;

        if (k == 0)
        begin : g_first
            assign p_vld   = tm_vld_reg;
            assign p_ip    = tm_ip_reg;
            assign p_f     = tm_f_reg;
            assign p_zero  = tm_zero_reg;
            assign p_pzero = tm_pzero_reg;
            assign p_r     = R_W'(31'h4000_0000);
            assign p_tag   = tm_tag_reg;
        end
        else
        begin : g_rest
            assign p_vld   = ex_vld_reg[k-1];
            assign p_ip    = ex_ip_reg[k-1];
            assign p_f     = ex_f_reg[k-1];
            assign p_zero  = ex_zero_reg[k-1];
            assign p_pzero = ex_pzero_reg[k-1];
            assign p_r     = ex_r_reg[k-1];
            assign p_tag   = ex_tag_reg[k-1];
        end

        always_comb
        begin
            prod   = (2*R_W)'(p_r) * (2*R_W)'(FAC);
            r_next = p_f[F_W-1-k] ? prod[30 +: R_W] : p_r;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ex_vld_reg[k] <= 1'b0;
            end
            else
            begin
                ex_vld_reg[k] <= p_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            ex_ip_reg[k]    <= p_ip;
            ex_f_reg[k]     <= p_f;
            ex_zero_reg[k]  <= p_zero;
            ex_pzero_reg[k] <= p_pzero;
            ex_r_reg[k]     <= r_next;
            ex_tag_reg[k]   <= p_tag;
        end
    end

    // integer part of t: shift; zero exponent gives one, zero cosine or t >= 17 gives zero
    logic           w_vld_reg;
    logic [W_W-1:0] w_reg;
    logic [W_W-1:0] w_next;
    tag_t           w_tag_reg;
    logic [IP_W-1:0] ip_last;
    logic [R_W-1:0]  r_last;

    assign ip_last = ex_ip_reg[EXP_STEPS-1];
    assign r_last  = ex_r_reg[EXP_STEPS-1];

    always_comb
    begin
        priority if (ex_pzero_reg[EXP_STEPS-1])
        begin
            w_next = 17'h1_0000;
        end
        else if (ex_zero_reg[EXP_STEPS-1] || (ip_last >= 12'd17))
        begin
            w_next = '0;
        end
        else
        begin
            w_next = W_W'(r_last >> (5'd14 + ip_last[4:0]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_vld_reg <= 1'b0;
        end
        else
        begin
            w_vld_reg <= ex_vld_reg[EXP_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg     <= w_next;
        w_tag_reg <= ex_tag_reg[EXP_STEPS-1];
    end

    assign out_vld = w_vld_reg;
    assign out_w   = w_reg;
    assign out_tag = w_tag_reg;

endmodule

@@ src/ramp_blinn_phong_shader.sv @@
`timescale 1ns / 1ps
// Top level of the ramp Blinn-Phong shader: config registers, dot products, ramp, output sum.
// Depends on rbp_pkg, rbp_rootdiv and rbp_pow.
//
//   channel | ports                                         | handshake
//   --------+-----------------------------------------------+----------------------------
//   input   | in_dir_*, out_dir_*, normal_*, hit_distance   | start && !busy
//   result  | color_red, color_green, color_blue            | done, one cycle, no stall
//   config  | wr_index, wr_data                             | wr_en
//
// One word enters per cycle; busy stays low. Each result passes through the 17-stage
// square root, 15-stage divider, 16-stage log2 squaring chain and 16-stage exp2 product
// chain. Nothing stalls: valid bits move every cycle. Reset clears the valid bits and
// loads the register defaults.
module ramp_blinn_phong_shader (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [15:0]            in_dir_x,
    input  logic signed [15:0]            in_dir_y,
    input  logic signed [15:0]            in_dir_z,
    input  logic signed [15:0]            out_dir_x,
    input  logic signed [15:0]            out_dir_y,
    input  logic signed [15:0]            out_dir_z,
    input  logic signed [15:0]            normal_x,
    input  logic signed [15:0]            normal_y,
    input  logic signed [15:0]            normal_z,
    input  logic [15:0]                   hit_distance,
    output logic                          done,
    output logic signed [15:0]            color_red,
    output logic signed [15:0]            color_green,
    output logic signed [15:0]            color_blue,
    input  logic                          wr_en,
    input  logic [rbp_pkg::IDX_W-1:0]     wr_index,
    input  logic [rbp_pkg::CFG_W-1:0]     wr_data
);
    import rbp_pkg::*;

    logic [CFG_W-1:0] amb_reg  [3];
    logic [CFG_W-1:0] spec_reg [3];
    logic [CFG_W-1:0] shin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amb_reg  <= '{default: '0};
            spec_reg <= '{default: '0};
            shin_reg <= SHIN_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_AMB_RED:   amb_reg[0]  <= wr_data;
                REG_AMB_GREEN: amb_reg[1]  <= wr_data;
                REG_AMB_BLUE:  amb_reg[2]  <= wr_data;
                REG_SPEC_RED:  spec_reg[0] <= wr_data;
                REG_SPEC_GRN:  spec_reg[1] <= wr_data;
                REG_SPEC_BLUE: spec_reg[2] <= wr_data;
                REG_SHININESS: shin_reg    <= wr_data;
                default:       ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage A: capture word
    logic               a_vld_reg;
    logic signed [15:0] a_wi_reg [3];
    logic signed [15:0] a_wo_reg [3];
    logic signed [15:0] a_n_reg  [3];
    logic [15:0]        a_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        a_wi_reg <= '{in_dir_x, in_dir_y, in_dir_z};
        a_wo_reg <= '{out_dir_x, out_dir_y, out_dir_z};
        a_n_reg  <= '{normal_x, normal_y, normal_z};
        a_d_reg  <= hit_distance;
    end

    // stage B: halfway vector, per-axis products, ramp color
    logic signed [16:0] h [3];
    logic signed [33:0] hsq [3];
    logic [12:0]        x_cl;
    logic [1:0]         seg;
    logic [2:0]         seg_lo;
    logic [2:0]         seg_hi;
    logic [10:0]        u;
    logic [24:0]        racc [3];

    logic               b_vld_reg;
    logic [32:0]        b_hh_reg [3];
    logic signed [32:0] b_dh_reg [3];
    logic signed [31:0] b_dn_reg [3];
    logic [RAMP_W-1:0]  b_ramp_reg [3];

    always_comb
    begin
        x_cl   = (a_d_reg > 16'd4096) ? 13'd4096 : a_d_reg[12:0];
        seg    = x_cl[12] ? 2'd3 : x_cl[11:10];
        seg_lo = {1'b0, seg};
        seg_hi = seg_lo + 3'd1;
        u      = x_cl[12] ? 11'd1024 : {1'b0, x_cl[9:0]};
        for (int j = 0; j < 3; j++)
        begin
            h[j]    = 17'(a_wi_reg[j]) + 17'(a_wo_reg[j]);
            hsq[j]  = 34'(h[j]) * 34'(h[j]);
            racc[j] = 25'(RAMP_PTS[seg_lo][j]) * 25'(11'd1024 - u)
                    + 25'(RAMP_PTS[seg_hi][j]) * 25'(u);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else
        begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            b_hh_reg[j]   <= hsq[j][32:0];
            b_dh_reg[j]   <= 33'(h[j]) * 33'(a_n_reg[j]);
            b_dn_reg[j]   <= 32'(a_wi_reg[j]) * 32'(a_n_reg[j]);
            b_ramp_reg[j] <= racc[j][10 +: RAMP_W];
        end
    end

    // stage C: sums
    logic                   c_vld_reg;
    logic [HH_W-1:0]        c_hh_reg;
    logic signed [DH_W-1:0] c_dh_reg;
    logic signed [DN_W-1:0] c_dn_reg;
    logic [RAMP_W-1:0]      c_ramp_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
        end
        else
        begin
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_hh_reg   <= HH_W'(b_hh_reg[0]) + HH_W'(b_hh_reg[1]) + HH_W'(b_hh_reg[2]);
        c_dh_reg   <= DH_W'(b_dh_reg[0]) + DH_W'(b_dh_reg[1]) + DH_W'(b_dh_reg[2]);
        c_dn_reg   <= DN_W'(b_dn_reg[0]) + DN_W'(b_dn_reg[1]) + DN_W'(b_dn_reg[2]);
        c_ramp_reg <= b_ramp_reg;
    end

    // stage D: diffuse term, floor of ramp * wIn.n / 2^28
    logic signed [47:0]     dprod [3];
    logic                   d_vld_reg;
    logic [HH_W-1:0]        d_hh_reg;
    logic signed [DH_W-1:0] d_dh_reg;
    tag_t                   d_tag_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            dprod[j] = 48'($signed({1'b0, c_ramp_reg[j]})) * 48'(c_dn_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= 1'b0;
        end
        else
        begin
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_hh_reg        <= c_hh_reg;
        d_dh_reg        <= c_dh_reg;
        d_tag_reg.red   <= dprod[0][28 +: DIFF_W];
        d_tag_reg.green <= dprod[1][28 +: DIFF_W];
        d_tag_reg.blue  <= dprod[2][28 +: DIFF_W];
    end

    logic           rd_vld;
    logic [C_W-1:0] rd_c;
    tag_t           rd_tag;
    logic           pw_vld;
    logic [W_W-1:0] pw_w;
    tag_t           pw_tag;

    rbp_rootdiv u_rootdiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (d_vld_reg),
        .in_hh   (d_hh_reg),
        .in_dh   (d_dh_reg),
        .in_tag  (d_tag_reg),
        .out_vld (rd_vld),
        .out_c   (rd_c),
        .out_tag (rd_tag)
    );

    rbp_pow u_pow (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (rd_vld),
        .in_c    (rd_c),
        .shin    (shin_reg),
        .in_tag  (rd_tag),
        .out_vld (pw_vld),
        .out_w   (pw_w),
        .out_tag (pw_tag)
    );

    // stage E: specular scale
    logic        e_vld_reg;
    logic [15:0] e_spec_reg [3];
    diff_t       e_diff_reg [3];
    logic [31:0] sprod [3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            sprod[j] = 32'(spec_reg[j]) * 32'(pw_w);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg <= 1'b0;
        end
        else
        begin
            e_vld_reg <= pw_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            e_spec_reg[j] <= sprod[j][31:16];
        end
        e_diff_reg <= '{pw_tag.red, pw_tag.green, pw_tag.blue};
    end

    // stage F: add ambient, saturate
    logic signed [18:0] sum [3];
    logic signed [15:0] sat [3];
    logic               f_vld_reg;
    logic signed [15:0] f_col_reg [3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            sum[j] = 19'(e_diff_reg[j]) + $signed(19'(e_spec_reg[j]))
                   + $signed(19'(amb_reg[j]));
            priority if (sum[j] > 19'sd32767)
            begin
                sat[j] = 16'sh7fff;
            end
            else if (sum[j] < -19'sd32768)
            begin
                sat[j] = -16'sh8000;
            end
            else
            begin
                sat[j] = sum[j][15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
            f_col_reg <= '{default: '0};
        end
        else
        begin
            f_vld_reg <= e_vld_reg;
            if (e_vld_reg)
            begin
                f_col_reg <= sat;
            end
        end
    end

    assign done        = f_vld_reg;
    assign color_red   = f_col_reg[0];
    assign color_green = f_col_reg[1];
    assign color_blue  = f_col_reg[2];

endmodule

@@ src/rbp_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the ramp Blinn-Phong shader, bound to the top level.
// Depends on rbp_pkg (pipeline latency).
module rbp_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      done,
    input logic signed [15:0]        color_red,
    input logic signed [15:0]        color_green,
    input logic signed [15:0]        color_blue
);
    import rbp_pkg::*;

    // every taken word comes out after the fixed latency
    a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("taken word did not come out");

    // no result without a word taken the fixed latency earlier
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a taken word");

    // color changes only with a strobe
    a_hold_color: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> ($stable(color_red) && $stable(color_green) && $stable(color_blue)))
        else $error("color changed without strobe");

    // the block never pushes back
    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

endmodule

bind ramp_blinn_phong_shader rbp_checker u_rbp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .color_red   (color_red),
    .color_green (color_green),
    .color_blue  (color_blue)
);
